@@ design/mwto_pkg.sv @@
// Shared types and constants of the multi-waveform tone oscillator.
package mwto_pkg;

	// Q.30 magnitude of a shaped value (at most 1.0)
	typedef logic [30:0] mag_t;

	// Waveform selector codes
	typedef enum logic [2:0] {
		WAVE_OFF    = 3'd0,
		WAVE_SINE   = 3'd1,
		WAVE_TRI    = 3'd2,
		WAVE_SAW    = 3'd3,
		WAVE_SQUARE = 3'd4
	} wave_sel_t;

	localparam logic [2:0] WAVE_RESET = WAVE_SAW;

	// Q.30 constants
	localparam longint Q30_ONE     = 64'sd1073741824;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam logic signed [33:0] SQUARE_Q30 = 34'sd751619276;

	// Sawtooth: floor(2^33 / 10) and the reciprocal of 5 for a 32-bit dividend
	localparam logic signed [33:0] SAW_BASE = 34'sd858993459;
	localparam logic [31:0] RECIP5 = 32'hCCCCCCCD;

	// Output limit
	localparam logic [16:0] SAMPLE_MAX = 17'd32767;

endpackage

@@ design/mwto_sine_rom.sv @@
// Quarter-wave sine table with a registered read port.
module mwto_sine_rom #(
	parameter int TABLE_BITS = 10
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic [TABLE_BITS:0]   addr,
	output mwto_pkg::mag_t        data
);
	import mwto_pkg::*;

	localparam int TAB_N = 1 << TABLE_BITS;

	// Entry k = sin(pi/2 * k / TAB_N) in Q.30, Horner series to x^13
	function automatic mag_t sine_entry(input int k);
		longint x;
		longint x2;
		longint term;
		longint s;
		x    = (longint'(k) * HALF_PI_Q30) >>> TABLE_BITS;
		x2   = (x * x) >>> 30;
		term = Q30_ONE;
		term = Q30_ONE - ((x2 * term) >>> 30) / 156;
		term = Q30_ONE - ((x2 * term) >>> 30) / 110;
		term = Q30_ONE - ((x2 * term) >>> 30) / 72;
		term = Q30_ONE - ((x2 * term) >>> 30) / 42;
		term = Q30_ONE - ((x2 * term) >>> 30) / 20;
		term = Q30_ONE - ((x2 * term) >>> 30) / 6;
		s    = (x * term) >>> 30;
		if (s > Q30_ONE) s = Q30_ONE;
		if (s < 0) s = 0;
		return mag_t'(s);
	endfunction

	mag_t rom_w [TAB_N+1];

	// Fill the table with constants
	for (genvar k = 0; k <= TAB_N; k++) begin : g_tab
		localparam mag_t ENTRY = sine_entry(k);
		assign rom_w[k] = ENTRY;
	end

	// Registered read, held while the stage stalls
	always_ff @(posedge clk) begin
		if (en) begin
			data <= rom_w[addr];
		end
	end

endmodule

@@ design/multi_waveform_tone_oscillator_unit.sv @@
// Top level of the multi-waveform tone oscillator (phase accumulator and shaping pipeline).
//
// Each input item on the s_axis channel asks for one signed 16-bit sample on m_axis.
// The input item carries the phase step and the Q1.15 amplitude in tdata and the
// restart flag in tuser; restart zeroes the phase before the sample is made.
// The waveform is chosen by the register written through cfg_wr_en/cfg_wr_data
// (0 silence, 1 sine, 2 triangle, 3 sawtooth, 4 square); write it only while idle.
// A result appears on m_axis once its item has passed five register stages (table
// read, divide-by-five multiply, shaping, gain multiply, output register), the first
// of which loads at the accepting edge.
// Throughput: one item per cycle while m_axis_tready does not stall the output; the
// phase accumulator updates on each accepted item, so nothing else bounds the rate.
// Each stage advances whenever the stage after it is empty or moving, so items
// keep entering while a finished sample waits on a stalled receiver until the
// pipeline is full; then s_axis_tready drops.
// Reset clears the phase to zero, selects the sawtooth and empties the pipeline.
module multi_waveform_tone_oscillator_unit #(
	parameter int PHASE_BITS      = 32,
	parameter int SINE_TABLE_BITS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_wr_data,    // waveform_select
	// input items
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // [31:0] freq_step, [47:32] amplitude
	input  logic        s_axis_tuser,   // [0] restart
	// result items
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata    // [15:0] sample (signed)
);
	import mwto_pkg::*;

	localparam int TB = SINE_TABLE_BITS;

	// Registers
	logic [PHASE_BITS-1:0] phase_q;
	logic [2:0]            waveform_q;

	logic        vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [31:0] phase_s1, phase_s2;
	logic [15:0] amp_s1, amp_s2, amp_s3;
	logic        nz_s1, nz_s2;
	mag_t        sine_s1, sine_s2;
	logic [27:0] quot_s2;
	mag_t        mag_s3;
	logic        neg_s3, neg_s4;
	logic [46:0] prod_s4;
	logic [15:0] sample_s5;

	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	logic accept;

	// Stage advance chain
	assign rdy5   = !vld_s5 || m_axis_tready;
	assign rdy4   = !vld_s4 || rdy5;
	assign rdy3   = !vld_s3 || rdy4;
	assign rdy2   = !vld_s2 || rdy3;
	assign rdy1   = !vld_s1 || rdy2;
	assign accept = s_axis_tvalid && rdy1;

	assign s_axis_tready = rdy1;
	assign m_axis_tvalid = vld_s5;
	assign m_axis_tdata  = sample_s5;

	// Input fields
	logic [31:0] step_w;
	logic [15:0] amp_w;
	assign step_w = s_axis_tdata[31:0];
	assign amp_w  = s_axis_tdata[47:32];

	// Current phase, its 32-bit fraction and the scaled step
	logic [PHASE_BITS-1:0]    cur_phase_w;
	logic [PHASE_BITS+31:0]   phase_wide_w;
	logic [PHASE_BITS+31:0]   step_wide_w;
	logic [31:0]              f32_w;
	logic [PHASE_BITS-1:0]    step_ext_w;

	assign cur_phase_w  = s_axis_tuser ? '0 : phase_q;
	assign phase_wide_w = {cur_phase_w, 32'd0};
	assign f32_w        = phase_wide_w[PHASE_BITS+31 -: 32];
	assign step_wide_w  = {step_w, {PHASE_BITS{1'b0}}};
	assign step_ext_w   = step_wide_w[32 +: PHASE_BITS];

	// Sine table address, mirrored in odd quadrants
	logic [TB-1:0] idx_w;
	logic [TB:0]   rom_addr_w;
	assign idx_w      = f32_w[29 -: TB];
	assign rom_addr_w = f32_w[30] ? ({1'b1, {TB{1'b0}}} - {1'b0, idx_w}) : {1'b0, idx_w};

	mwto_sine_rom #(
		.TABLE_BITS(TB)
	) u_sine_rom (
		.clk  (clk),
		.en   (rdy1),
		.addr (rom_addr_w),
		.data (sine_s1)
	);

	// Configuration register and phase accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waveform_q <= WAVE_RESET;
			phase_q    <= '0;
		end else begin
			if (cfg_wr_en) begin
				waveform_q <= cfg_wr_data;
			end
			if (accept) begin
				phase_q <= cur_phase_w + step_ext_w;
			end
		end
	end

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= s_axis_tvalid;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
			if (rdy4) vld_s4 <= vld_s3;
			if (rdy5) vld_s5 <= vld_s4;
		end
	end

	// Stage 1: divide the 30-bit phase fraction by five
	logic [63:0] recip_prod_w;
	assign recip_prod_w = 64'(phase_s1[31:2]) * 64'(RECIP5);

	// Stage 2: shape the phase into a signed Q.30 value
	logic [29:0]        f30_w;
	logic [29:0]        quot5_w;
	logic [2:0]         rem_w;
	logic [30:0]        quot9_w;
	logic signed [33:0] saw_a_w;
	logic signed [33:0] saw_d_w;
	logic signed [33:0] saw_fl_w;
	logic signed [33:0] saw_y_w;
	logic signed [33:0] tri4_w;
	logic signed [33:0] shaped_w;
	mag_t               mag_w;
	logic               neg_w;

	assign f30_w    = phase_s2[31:2];
	assign quot5_w  = {quot_s2, 2'b00} + {2'b00, quot_s2};
	assign rem_w    = 3'(f30_w - quot5_w);
	assign quot9_w  = {quot_s2, 3'b000} + {3'b000, quot_s2};
	assign saw_a_w  = SAW_BASE - $signed({3'b000, quot9_w});
	assign saw_fl_w = saw_a_w + saw_d_w;
	assign tri4_w   = $signed({2'b00, f30_w, 2'b00});

	// Floor correction for the remainder of the phase over five
	always_comb begin
		case (rem_w)
			3'd0:    saw_d_w = 34'sd0;
			3'd1:    saw_d_w = -34'sd2;
			3'd2:    saw_d_w = -34'sd4;
			3'd3:    saw_d_w = -34'sd6;
			default: saw_d_w = -34'sd7;
		endcase
	end

	// Round a negative inexact quotient toward zero
	assign saw_y_w = saw_fl_w + 34'((saw_fl_w < 0) && (rem_w != 3'd4));

	// Select the waveform and split into sign and magnitude
	always_comb begin
		shaped_w = '0;
		case (waveform_q)
			WAVE_TRI: begin
				if (f30_w < 30'h1000_0000) begin
					shaped_w = tri4_w;
				end else if (f30_w < 30'h3000_0000) begin
					shaped_w = 34'sh0_8000_0000 - tri4_w;
				end else begin
					shaped_w = tri4_w - 34'sh1_0000_0000;
				end
			end
			WAVE_SAW:    shaped_w = saw_y_w;
			WAVE_SQUARE: shaped_w = phase_s2[31] ? -SQUARE_Q30 : SQUARE_Q30;
			default:     shaped_w = '0;
		endcase
		if (waveform_q == WAVE_SINE) begin
			mag_w = sine_s2;
			neg_w = phase_s2[31];
		end else begin
			neg_w = shaped_w[33];
			mag_w = neg_w ? mag_t'(-shaped_w) : mag_t'(shaped_w);
		end
		if (!nz_s2) begin
			mag_w = '0;
		end
	end

	// Stage 4: apply 32767 and saturate
	logic [61:0] scaled_w;
	logic [16:0] mag17_w;
	logic [14:0] sat_w;
	assign scaled_w = {prod_s4, 15'd0} - {15'd0, prod_s4};
	assign mag17_w  = scaled_w[61:45];
	assign sat_w    = (mag17_w > SAMPLE_MAX) ? SAMPLE_MAX[14:0] : mag17_w[14:0];

	// Pipeline payload registers
	always_ff @(posedge clk) begin
		if (rdy1) begin
			phase_s1 <= f32_w;
			amp_s1   <= amp_w;
			nz_s1    <= (step_w != 32'd0);
		end
		if (rdy2) begin
			phase_s2 <= phase_s1;
			amp_s2   <= amp_s1;
			nz_s2    <= nz_s1;
			sine_s2  <= sine_s1;
			quot_s2  <= recip_prod_w[61:34];
		end
		if (rdy3) begin
			mag_s3 <= mag_w;
			neg_s3 <= neg_w;
			amp_s3 <= amp_s2;
		end
		if (rdy4) begin
			prod_s4 <= 47'(mag_s3) * 47'(amp_s3);
			neg_s4  <= neg_s3;
		end
		if (rdy5) begin
			sample_s5 <= neg_s4 ? -{1'b0, sat_w} : {1'b0, sat_w};
		end
	end

endmodule
